// ===== rtl/core/pav_pkg.sv =====
// ----------------------------------------------------------------------------
// pav_pkg
// Shared types, codes and helpers for the particle advance pipeline.
// ----------------------------------------------------------------------------
package pav_pkg;

  localparam int POS_WIDTH = 32;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES = 31;

  typedef enum logic [1:0] {
    MODE_OPEN   = 2'd0,
    MODE_MIRROR = 2'd1,
    MODE_WRAP   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_DEPTH  = 2'd3
  } reg_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic [2:0]         neg;
    logic               zero;
  } side_t;

  typedef struct packed {
    logic [63:0]       s;
    logic [2:0][61:0]  prod;
    side_t             side;
  } sq_beat_t;

  typedef struct packed {
    logic [31:0]       r;
    logic [2:0][61:0]  prod;
    side_t             side;
  } dv_beat_t;

  typedef struct packed {
    logic [2:0][30:0]  q;
    side_t             side;
  } bd_beat_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic signed [31:0] new_vel_x;
    logic               in_domain;
  } res_t;

  localparam logic signed [35:0] POS_MAX = (36'sd1 <<< (POS_WIDTH - 1)) - 36'sd1;
  localparam logic signed [35:0] POS_MIN = -POS_MAX - 36'sd1;

  function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == 32'sh8000_0000) begin
      r = 32'sh7fff_ffff;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_pos(input logic signed [35:0] v);
    logic signed [35:0] c;
    if (v > POS_MAX) begin
      c = POS_MAX;
    end else if (v < POS_MIN) begin
      c = POS_MIN;
    end else begin
      c = v;
    end
    return c[31:0];
  endfunction

endpackage

// ===== rtl/core/pav_norm.sv =====
// ----------------------------------------------------------------------------
// pav_norm
// Velocity magnitudes, normalizing shift, squares, step products and sum.
// ----------------------------------------------------------------------------
module pav_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               v_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [30:0]        step_len_i,
  output logic               v_o,
  output pav_pkg::sq_beat_t  beat_o
);

  logic [3:0] v_q;

  logic [2:0][31:0] mag_d, mag1_q, sh_d, sh2_q;
  logic [31:0]      max_d, max1_q;
  logic [30:0]      len1_q, len2_q;
  pav_pkg::side_t   side_d, side1_q, side2_q, side3_q, side4_q;
  logic [4:0]       k_d;
  logic [2:0][63:0] sq_d, sq3_q;
  logic [2:0][61:0] pr_d, pr3_q, pr4_q;
  logic [63:0]      s_d, s4_q;
  logic [62:0]      pr_full [3];

  always_comb begin
    mag_d[0] = vel_x_i[31] ? 32'(-vel_x_i) : vel_x_i;
    mag_d[1] = vel_y_i[31] ? 32'(-vel_y_i) : vel_y_i;
    mag_d[2] = vel_z_i[31] ? 32'(-vel_z_i) : vel_z_i;
    max_d = mag_d[0];
    if (mag_d[1] > max_d) begin
      max_d = mag_d[1];
    end
    if (mag_d[2] > max_d) begin
      max_d = mag_d[2];
    end
    side_d.pos_x = pos_x_i;
    side_d.pos_y = pos_y_i;
    side_d.pos_z = pos_z_i;
    side_d.vel_x = vel_x_i;
    side_d.neg   = {vel_z_i[31], vel_y_i[31], vel_x_i[31]};
    side_d.zero  = (max_d == 32'd0);
  end

  always_comb begin
    k_d = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (max1_q[i]) begin
        k_d = 5'(30 - i);
      end
    end
    if (max1_q[31]) begin
      k_d = 5'd0;
    end
    for (int j = 0; j < 3; j++) begin
      sh_d[j] = mag1_q[j] << k_d;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_d[j]    = 64'(sh2_q[j]) * 64'(sh2_q[j]);
      pr_full[j] = 63'(len2_q) * 63'(sh2_q[j]);
      pr_d[j]    = pr_full[j][61:0];
    end
  end

  assign s_d = sq3_q[0] + sq3_q[1] + sq3_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d;
      max1_q  <= max_d;
      len1_q  <= step_len_i;
      side1_q <= side_d;
      sh2_q   <= sh_d;
      len2_q  <= len1_q;
      side2_q <= side1_q;
      sq3_q   <= sq_d;
      pr3_q   <= pr_d;
      side3_q <= side2_q;
      s4_q    <= s_d;
      pr4_q   <= pr3_q;
      side4_q <= side3_q;
    end
  end

  assign v_o         = v_q[3];
  assign beat_o.s    = s4_q;
  assign beat_o.prod = pr4_q;
  assign beat_o.side = side4_q;

endmodule

// ===== rtl/core/pav_sqrt.sv =====
// ----------------------------------------------------------------------------
// pav_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module pav_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               v_i,
  input  pav_pkg::sq_beat_t  beat_i,
  output logic               v_o,
  output pav_pkg::dv_beat_t  beat_o
);

  localparam int N = pav_pkg::SQRT_STAGES;

  logic [N-1:0]     v_q;
  logic [33:0]      rem_in [N];
  logic [33:0]      rem_d  [N];
  logic [33:0]      rem_q  [N];
  logic [31:0]      root_in [N];
  logic [31:0]      root_d  [N];
  logic [31:0]      root_q  [N];
  logic [63:0]      sh_in [N];
  logic [63:0]      sh_d  [N];
  logic [63:0]      sh_q  [N];
  logic [2:0][61:0] pr_in [N];
  logic [2:0][61:0] pr_q  [N];
  pav_pkg::side_t   sd_in [N];
  pav_pkg::side_t   sd_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [35:0] rem_n;
    logic [35:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in[i]  = '0;
      assign root_in[i] = '0;
      assign sh_in[i]   = beat_i.s;
      assign pr_in[i]   = beat_i.prod;
      assign sd_in[i]   = beat_i.side;
    end else begin : g_next
      assign rem_in[i]  = rem_q[i-1];
      assign root_in[i] = root_q[i-1];
      assign sh_in[i]   = sh_q[i-1];
      assign pr_in[i]   = pr_q[i-1];
      assign sd_in[i]   = sd_q[i-1];
    end

    always_comb begin
      rem_n     = {rem_in[i], sh_in[i][63:62]};
      trial     = {2'b00, root_in[i], 2'b01};
      ge        = (rem_n >= trial);
      rem_d[i]  = ge ? 34'(rem_n - trial) : rem_n[33:0];
      root_d[i] = {root_in[i][30:0], ge};
      sh_d[i]   = {sh_in[i][61:0], 2'b00};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
        sh_q[i]   <= sh_d[i];
        pr_q[i]   <= pr_in[i];
        sd_q[i]   <= sd_in[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], v_i};
    end
  end

  assign v_o         = v_q[N-1];
  assign beat_o.r    = root_q[N-1];
  assign beat_o.prod = pr_q[N-1];
  assign beat_o.side = sd_q[N-1];

endmodule

// ===== rtl/core/pav_div.sv =====
// ----------------------------------------------------------------------------
// pav_div
// Rounded quotient for three axes, pipelined restoring division.
// ----------------------------------------------------------------------------
module pav_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               v_i,
  input  pav_pkg::dv_beat_t  beat_i,
  output logic               v_o,
  output pav_pkg::bd_beat_t  beat_o
);

  localparam int N = pav_pkg::DIV_STAGES;

  logic [N:0]       v_q;
  logic [2:0][62:0] num;
  logic [2:0][31:0] rem0_q;
  logic [2:0][30:0] low0_q;
  logic [31:0]      r0_q;
  pav_pkg::side_t   sd0_q;

  logic [2:0][31:0] rem_in [N];
  logic [2:0][31:0] rem_d  [N];
  logic [2:0][31:0] rem_q  [N];
  logic [2:0][30:0] low_in [N];
  logic [2:0][30:0] low_d  [N];
  logic [2:0][30:0] low_q  [N];
  logic [2:0][30:0] q_in [N];
  logic [2:0][30:0] q_d  [N];
  logic [2:0][30:0] q_q  [N];
  logic [31:0]      r_in [N];
  logic [31:0]      r_q  [N];
  pav_pkg::side_t   sd_in [N];
  pav_pkg::side_t   sd_q  [N];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num[j] = {1'b0, beat_i.prod[j]} + {32'd0, beat_i.r[31:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        rem0_q[j] <= num[j][62:31];
        low0_q[j] <= num[j][30:0];
      end
      r0_q  <= beat_i.r;
      sd0_q <= beat_i.side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [32:0] rem_n [3];
    logic        ge    [3];

    if (i == 0) begin : g_first
      assign rem_in[i] = rem0_q;
      assign low_in[i] = low0_q;
      assign q_in[i]   = '0;
      assign r_in[i]   = r0_q;
      assign sd_in[i]  = sd0_q;
    end else begin : g_next
      assign rem_in[i] = rem_q[i-1];
      assign low_in[i] = low_q[i-1];
      assign q_in[i]   = q_q[i-1];
      assign r_in[i]   = r_q[i-1];
      assign sd_in[i]  = sd_q[i-1];
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        rem_n[j]     = {rem_in[i][j], low_in[i][j][30]};
        ge[j]        = (rem_n[j] >= {1'b0, r_in[i]});
        rem_d[i][j]  = ge[j] ? 32'(rem_n[j] - {1'b0, r_in[i]}) : rem_n[j][31:0];
        q_d[i][j]    = {q_in[i][j][29:0], ge[j]};
        low_d[i][j]  = {low_in[i][j][29:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d[i];
        low_q[i] <= low_d[i];
        q_q[i]   <= q_d[i];
        r_q[i]   <= r_in[i];
        sd_q[i]  <= sd_in[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-1:0], v_i};
    end
  end

  assign v_o         = v_q[N];
  assign beat_o.q    = q_q[N-1];
  assign beat_o.side = sd_q[N-1];

endmodule

// ===== rtl/core/pav_bound.sv =====
// ----------------------------------------------------------------------------
// pav_bound
// Position update, x boundary rule, y wrap, inside test and saturation.
// ----------------------------------------------------------------------------
module pav_bound (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               v_i,
  input  pav_pkg::bd_beat_t  beat_i,
  input  logic [1:0]         mode_i,
  input  logic [30:0]        width_x_i,
  input  logic [30:0]        height_z_i,
  input  logic [30:0]        depth_y_i,
  output logic               v_o,
  output pav_pkg::res_t      res_o
);

  logic [3:0] v_q;

  logic signed [35:0] w, h, dp;
  logic signed [35:0] d [3];
  logic signed [35:0] x1_d, y1_d, z1_d, x1_q, y1_q, z1_q;
  logic signed [35:0] x2_d, y2_d, x2_q, y2_q, z2_q;
  logic signed [35:0] x3_d, y3_d, x3_q, y3_q, z3_q;
  logic signed [31:0] vx1_q, vx2_d, vx2_q, vx3_d, vx3_q;
  logic               in3_d, in3_q;
  pav_pkg::res_t      res_d, res_q;

  assign w  = $signed({5'd0, width_x_i});
  assign h  = $signed({5'd0, height_z_i});
  assign dp = $signed({5'd0, depth_y_i});

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (beat_i.side.zero) begin
        d[j] = '0;
      end else if (beat_i.side.neg[j]) begin
        d[j] = -$signed({5'd0, beat_i.q[j]});
      end else begin
        d[j] = $signed({5'd0, beat_i.q[j]});
      end
    end
    x1_d = 36'(beat_i.side.pos_x) + d[0];
    y1_d = 36'(beat_i.side.pos_y) + d[1];
    z1_d = 36'(beat_i.side.pos_z) + d[2];
  end

  always_comb begin
    x2_d  = x1_q;
    vx2_d = vx1_q;
    case (mode_i)
      pav_pkg::MODE_OPEN: begin
        x2_d = x1_q;
      end
      pav_pkg::MODE_MIRROR: begin
        if (x1_q < 0) begin
          x2_d  = -x1_q;
          vx2_d = pav_pkg::neg_sat32(vx1_q);
        end
      end
      default: begin
        if (x1_q < 0) begin
          x2_d = w + x1_q;
        end
      end
    endcase
    y2_d = (y1_q < 0) ? dp + y1_q : y1_q;
  end

  always_comb begin
    x3_d  = x2_q;
    vx3_d = vx2_q;
    in3_d = !(z2_q < 0 || z2_q > h);
    case (mode_i)
      pav_pkg::MODE_OPEN: begin
        if (x2_q < 0 || x2_q > w) begin
          in3_d = 1'b0;
        end
      end
      pav_pkg::MODE_MIRROR: begin
        if (x2_q > w) begin
          x3_d  = (w <<< 1) - x2_q;
          vx3_d = pav_pkg::neg_sat32(vx2_q);
        end
      end
      default: begin
        if (x2_q > w) begin
          x3_d = x2_q - w;
        end
      end
    endcase
    y3_d = (y2_q > dp) ? y2_q - dp : y2_q;
  end

  always_comb begin
    res_d.new_x     = pav_pkg::sat_pos(x3_q);
    res_d.new_y     = pav_pkg::sat_pos(y3_q);
    res_d.new_z     = pav_pkg::sat_pos(z3_q);
    res_d.new_vel_x = vx3_q;
    res_d.in_domain = in3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= x1_d;
      y1_q  <= y1_d;
      z1_q  <= z1_d;
      vx1_q <= beat_i.side.vel_x;
      x2_q  <= x2_d;
      y2_q  <= y2_d;
      z2_q  <= z1_q;
      vx2_q <= vx2_d;
      x3_q  <= x3_d;
      y3_q  <= y3_d;
      z3_q  <= z2_q;
      vx3_q <= vx3_d;
      in3_q <= in3_d;
      res_q <= res_d;
    end
  end

  assign v_o   = v_q[3];
  assign res_o = res_q;

endmodule

// ===== rtl/core/particle_advance_with_boundaries_unit.sv =====
// ----------------------------------------------------------------------------
// particle_advance_with_boundaries_unit
// Pipeline: 4 normalize, 32 sqrt, 32 divide and 4 boundary stages.
// Throughput: one beat per cycle while the output is not stalled; the
// sqrt and divide units are fully pipelined, one bit per stage.
// Reset: clears all valid bits and loads mode 2 (wrap), width 64.0,
// height 64.0, depth 1.0. A stalled output holds the whole pipeline.
// ----------------------------------------------------------------------------
module particle_advance_with_boundaries_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [30:0]        step_len_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic               inside_res_o
);

  logic [1:0]  mode_q;
  logic [30:0] width_q, height_q, depth_q;
  logic        wr;
  logic        en;

  logic              nv, sv, dv, bv;
  pav_pkg::sq_beat_t nb;
  pav_pkg::dv_beat_t sb;
  pav_pkg::bd_beat_t db;
  pav_pkg::res_t     res;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pav_pkg::MODE_WRAP;
      width_q  <= 31'd4194304;
      height_q <= 31'd4194304;
      depth_q  <= 31'd65536;
    end else if (wr) begin
      case (paddr[3:2])
        pav_pkg::REG_MODE:   mode_q   <= pwdata[1:0];
        pav_pkg::REG_WIDTH:  width_q  <= pwdata[30:0];
        pav_pkg::REG_HEIGHT: height_q <= pwdata[30:0];
        pav_pkg::REG_DEPTH:  depth_q  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pav_pkg::REG_MODE:   prdata = {30'd0, mode_q};
      pav_pkg::REG_WIDTH:  prdata = {1'b0, width_q};
      pav_pkg::REG_HEIGHT: prdata = {1'b0, height_q};
      pav_pkg::REG_DEPTH:  prdata = {1'b0, depth_q};
      default:             prdata = '0;
    endcase
  end

  assign en         = ~bv | out_ready_i;
  assign in_ready_o = en;

  pav_norm u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .v_i        (in_valid_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .vel_x_i    (vel_x_i),
    .vel_y_i    (vel_y_i),
    .vel_z_i    (vel_z_i),
    .step_len_i (step_len_i),
    .v_o        (nv),
    .beat_o     (nb)
  );

  pav_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (nv),
    .beat_i (nb),
    .v_o    (sv),
    .beat_o (sb)
  );

  pav_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (sv),
    .beat_i (sb),
    .v_o    (dv),
    .beat_o (db)
  );

  pav_bound u_bound (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .v_i        (dv),
    .beat_i     (db),
    .mode_i     (mode_q),
    .width_x_i  (width_q),
    .height_z_i (height_q),
    .depth_y_i  (depth_q),
    .v_o        (bv),
    .res_o      (res)
  );

  assign out_valid_o  = bv;
  assign new_x_o      = res.new_x;
  assign new_y_o      = res.new_y;
  assign new_z_o      = res.new_z;
  assign new_vel_x_o  = res.new_vel_x;
  assign inside_res_o = res.in_domain;

endmodule

// ===== sim/particle_advance_with_boundaries_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_advance_with_boundaries_unit_tb
// Streams particles through the advance unit over several boundary setups,
// predicts each result beat with a local integer model or a given result and compares fields.
// ----------------------------------------------------------------------------
module particle_advance_with_boundaries_unit_tb;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic [30:0]        len;
  } particle_t;

  typedef struct {
    particle_t     p;
    bit            known;
    pav_pkg::res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [30:0] step_len_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] new_x_o, new_y_o, new_z_o, new_vel_x_o;
  logic inside_res_o;

  particle_advance_with_boundaries_unit dut (.*);

  always #2 clk_i = ~clk_i;

  logic [1:0]    cur_mode;
  logic [30:0]   cur_width, cur_height, cur_depth;
  pav_pkg::res_t pending_q[$];
  int            n_errors = 0;
  int            n_mismatch = 0;
  longint        n_cycles = 0;
  bit            out_busy = 1'b1;
  bit            in_busy = 1'b1;

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > 64'd2000000) begin
      $display("particle_advance_with_boundaries_unit verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] flip_vel(input logic signed [31:0] v);
    return (v == 32'sh80000000) ? 32'sh7fffffff : -v;
  endfunction

  function automatic pav_pkg::res_t advance(input particle_t p);
    longint        pos[3], vel[3], d[3], x, y, z, w;
    logic [63:0]   a[3], m, s, r, q;
    logic signed [31:0] vx;
    bit            x_exit;
    pav_pkg::res_t o;
    pos = '{p.px, p.py, p.pz};
    vel = '{p.vx, p.vy, p.vz};
    d = '{0, 0, 0};
    x_exit = 0;
    for (int i = 0; i < 3; i++) a[i] = vel[i] < 0 ? -vel[i] : vel[i];
    m = a[0];
    if (a[1] > m) m = a[1];
    if (a[2] > m) m = a[2];
    if (m != 0) begin
      while (m < (64'd1 << 30)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) a[i] <<= 1;
      end
      s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      r = isqrt(s);
      for (int i = 0; i < 3; i++) begin
        q = (64'(p.len) * a[i] + (r >> 1)) / r;
        d[i] = vel[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    x = pos[0] + d[0];
    y = pos[1] + d[1];
    z = pos[2] + d[2];
    vx = p.vx;
    w = cur_width;
    if (cur_mode == pav_pkg::MODE_OPEN) begin
      x_exit = (x < 0) || (x > w);
    end else if (cur_mode == pav_pkg::MODE_MIRROR) begin
      if (x < 0) begin
        x = -x;
        vx = flip_vel(vx);
      end
      if (x > w) begin
        x = 2 * w - x;
        vx = flip_vel(vx);
      end
    end else begin
      if (x < 0) x = w + x;
      if (x > w) x = x - w;
    end
    if (y < 0) y = longint'(cur_depth) + y;
    if (y > longint'(cur_depth)) y = y - longint'(cur_depth);
    o.new_x = clamp32(x);
    o.new_y = clamp32(y);
    o.new_z = clamp32(z);
    o.new_vel_x = vx;
    o.in_domain = !(z < 0 || z > longint'(cur_height)) && !x_exit;
    return o;
  endfunction

  task automatic write_reg(input pav_pkg::reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pav_pkg::REG_MODE:   cur_mode = val[1:0];
      pav_pkg::REG_WIDTH:  cur_width = val[30:0];
      pav_pkg::REG_HEIGHT: cur_height = val[30:0];
      default:             cur_depth = val[30:0];
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(input particle_t p, input bit known, input pav_pkg::res_t res);
    while (in_busy && ($urandom_range(99) < 13)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= p.px; pos_y_i <= p.py; pos_z_i <= p.pz;
    vel_x_i <= p.vx; vel_y_i <= p.vy; vel_z_i <= p.vz;
    step_len_i <= p.len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(known ? res : advance(p));
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_ready_i <= !(out_busy && ($urandom_range(99) < 13));

  always @(posedge clk_i) begin
    pav_pkg::res_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_mismatch++ < 10) $display("unexpected result beat");
      end else begin
        e = pending_q.pop_front();
        if (e.new_x !== new_x_o || e.new_y !== new_y_o || e.new_z !== new_z_o ||
            e.new_vel_x !== new_vel_x_o || e.in_domain !== inside_res_o) begin
          n_errors++;
          if (n_mismatch++ < 10)
            $display("mismatch exp x=%0d y=%0d z=%0d vx=%0d in=%0b got %0d %0d %0d %0d %0b",
                     e.new_x, e.new_y, e.new_z, e.new_vel_x, e.in_domain, new_x_o,
                     new_y_o, new_z_o, new_vel_x_o, inside_res_o);
        end
      end
    end
  end

  task automatic drain;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rnd_word(input int mode_sel);
    case (mode_sel)
      0: return $urandom;
      1: return $signed(32'($urandom_range(8388608))) - 32'sd1048576;
      default: return $signed(32'($urandom_range(2000))) - 32'sd1000;
    endcase
  endfunction

  function automatic particle_t rnd_particle;
    particle_t p;
    int sel;
    sel = $urandom_range(9);
    p.px = rnd_word(sel == 0 ? 0 : 1);
    p.py = rnd_word(sel == 0 ? 0 : 1);
    p.pz = rnd_word(sel == 0 ? 0 : 1);
    p.vx = rnd_word(sel < 3 ? 0 : 2);
    p.vy = rnd_word(sel < 3 ? 0 : 2);
    p.vz = rnd_word(sel < 3 ? 0 : 2);
    if ($urandom_range(15) == 0) p.vy = 0;
    p.len = (sel == 0) ? 31'($urandom) : 31'($urandom_range(1 << 21));
    return p;
  endfunction

  row_t dir_rows[$];

  function automatic row_t mk(input logic signed [31:0] px, py, pz, vx, vy, vz,
                              input logic [30:0] len, input bit known = 0,
                              input pav_pkg::res_t res = '0);
    row_t r;
    r.p = '{px, py, pz, vx, vy, vz, len};
    r.known = known;
    r.res = res;
    return r;
  endfunction

  initial begin
    particle_t p;
    cur_mode = pav_pkg::MODE_WRAP;
    cur_width = 31'd4194304;
    cur_height = 31'd4194304;
    cur_depth = 31'd65536;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // zero velocity: unchanged, after-reset settings
    dir_rows.push_back(mk(100, 200, 300, 0, 0, 0, 31'h7fffffff, 1,
                          '{100, 200, 300, 0, 1'b1}));
    dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 1'b1}));
    dir_rows.push_back(mk(4194304, 65536, 4194304, 0, 0, 0, 5, 1,
                          '{4194304, 65536, 4194304, 0, 1'b1}));
    dir_rows.push_back(mk(0, 0, -1, 0, 0, 0, 0, 1, '{0, 0, -1, 0, 1'b0}));
    dir_rows.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff));
    dir_rows.push_back(mk(32'sh80000000, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff));
    dir_rows.push_back(mk(-5, -7, 10, -1, 1, 1, 1000));
    dir_rows.push_back(mk(4194300, 60000, 20, 1, 0, 0, 65536));
    dir_rows.push_back(mk(10, 10, 10, 32'sh80000000, 0, 0, 65536));
    dir_rows.push_back(mk(100, 100, 100, 3, -4, 12, 31'h7fffffff));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(pav_pkg::REG_MODE, 32'(pav_pkg::MODE_OPEN));
          write_reg(pav_pkg::REG_WIDTH, 32'd1);
          write_reg(pav_pkg::REG_HEIGHT, 32'h7fffffff);
          write_reg(pav_pkg::REG_DEPTH, 32'd1);
        end
        2: begin
          write_reg(pav_pkg::REG_MODE, 32'(pav_pkg::MODE_MIRROR));
          write_reg(pav_pkg::REG_WIDTH, 32'h7fffffff);
          write_reg(pav_pkg::REG_HEIGHT, 32'd1);
          write_reg(pav_pkg::REG_DEPTH, 32'h7fffffff);
        end
        3: begin
          write_reg(pav_pkg::REG_MODE, 32'(pav_pkg::MODE_MIRROR));
          write_reg(pav_pkg::REG_WIDTH, 32'd2097152);
          write_reg(pav_pkg::REG_HEIGHT, 32'd2097152);
          write_reg(pav_pkg::REG_DEPTH, 32'd1048576);
        end
        4: begin
          write_reg(pav_pkg::REG_MODE, 32'(pav_pkg::MODE_OPEN));
          write_reg(pav_pkg::REG_WIDTH, 32'd4194304);
          write_reg(pav_pkg::REG_HEIGHT, 32'd4194304);
        end
        5: begin
          write_reg(pav_pkg::REG_MODE, 32'd3);
          write_reg(pav_pkg::REG_WIDTH, 32'hffffffff);
          write_reg(pav_pkg::REG_DEPTH, 32'd0);
        end
        default: ;
      endcase
      in_busy = (ph != 2);
      out_busy = (ph != 2);
      foreach (dir_rows[i])
        send(dir_rows[i].p, ph == 0 && dir_rows[i].known, dir_rows[i].res);
      for (int n = 0; n < 230; n++) begin
        p = rnd_particle();
        send(p, 0, '0);
      end
      in_valid_i <= 1'b0;
      drain();
    end

    if (n_errors == 0) begin
      $display("particle_advance_with_boundaries_unit verification clean");
    end else begin
      $display("particle_advance_with_boundaries_unit verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/pav_pkg.sv
rtl/core/pav_norm.sv
rtl/core/pav_sqrt.sv
rtl/core/pav_div.sv
rtl/core/pav_bound.sv
rtl/core/particle_advance_with_boundaries_unit.sv
sim/particle_advance_with_boundaries_unit_tb.sv
